// ===== rtl/b64le_pkg.sv =====
package b64le_pkg;

   localparam logic [7:0] LINE_LENGTH_RESET = 8'd72;
   localparam logic [7:0] PAD_CHAR          = 8'd61;
   localparam logic [7:0] NEWLINE_CHAR      = 8'd10;
   localparam int         QUEUE_DEPTH_DEF   = 2;
   localparam int         JOB_CHARS         = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
      logic       message_end;
   } rsp_type;

   typedef struct packed {
      logic [JOB_CHARS-1:0][7:0] chars;
      logic [1:0]                last_idx;
      logic                      msg_end;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)      return 8'd65 + w;
      else if (v < 6'd52) return 8'd71 + w;
      else if (v < 6'd62) return w - 8'd4;
      else if (v == 6'd62) return 8'd43;
      else                return 8'd47;
   endfunction

endpackage

// ===== rtl/b64le_front.sv =====
module b64le_front
   import b64le_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_en,
   input  logic [7:0]   csr_write_data,
   input  logic         accept,
   input  req_type      req_data,
   output job_type      job
);

   typedef enum logic [1:0] {PH0, PH1, PH2} phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] line_length_ff;
   logic [7:0] count_sum;
   logic [7:0] b;
   logic       fin;

   assign b         = req_data.data_byte;
   assign fin       = req_data.final_byte;
   assign count_sum = count_ff + 8'd4;

   always_comb begin
      job.chars   = '0;
      job.last_idx = 2'd0;
      job.msg_end = fin;
      phase_in    = phase_ff;
      carry_in    = carry_ff;
      count_in    = count_ff;
      unique case (phase_ff)
         PH1: begin
            job.chars[0] = sym({carry_ff[1:0], b[7:4]});
            carry_in     = b[3:0];
            phase_in     = PH2;
            if (fin) begin
               job.chars[1] = sym({b[3:0], 2'b00});
               job.chars[2] = PAD_CHAR;
               job.last_idx = 2'd2;
            end
         end
         PH2: begin
            job.chars[0] = sym({carry_ff, b[7:6]});
            job.chars[1] = sym(b[5:0]);
            job.last_idx = 2'd1;
            carry_in     = 4'd0;
            phase_in     = PH0;
            count_in     = count_sum;
            if (line_length_ff != 8'd0 && count_sum == line_length_ff) begin
               job.chars[2] = NEWLINE_CHAR;
               job.last_idx = 2'd2;
               count_in     = 8'd0;
            end
         end
         default: begin
            job.chars[0] = sym(b[7:2]);
            carry_in     = {2'b00, b[1:0]};
            phase_in     = PH1;
            if (fin) begin
               job.chars[1] = sym({b[1:0], 4'b0000});
               job.chars[2] = PAD_CHAR;
               job.chars[3] = PAD_CHAR;
               job.last_idx = 2'd3;
            end
         end
      endcase
      if (fin) begin
         phase_in = PH0;
         carry_in = 4'd0;
         count_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH0;
         carry_ff       <= 4'd0;
         count_ff       <= 8'd0;
         line_length_ff <= LINE_LENGTH_RESET;
      end else begin
         if (csr_write_en) begin
            line_length_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            carry_ff <= carry_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// ===== rtl/b64le_queue.sv =====
module b64le_queue
   import b64le_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head,
   output q_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/b64le_back.sv =====
module b64le_back
   import b64le_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head,
   input  q_status_type status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic [1:0] idx_ff;
   logic       out_free;
   logic       load;
   logic       at_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = out_free && !status.empty;
   assign at_last  = (idx_ff == head.last_idx);
   assign pop      = load && at_last;

   assign rsp_in.out_char    = head.chars[idx_ff];
   assign rsp_in.run_end     = at_last;
   assign rsp_in.message_end = at_last && head.msg_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (out_free) begin
         rsp_valid_ff <= load;
         if (load) begin
            idx_ff <= at_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

endmodule

// ===== rtl/base64_line_encoder.sv =====
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_data  (req_type: data_byte, final_byte)
// rsp      out        rsp_valid / rsp_stall   rsp_data  (rsp_type: out_char, run_end,
//                                                        message_end)
// csr      in         csr_write_en            csr_write_data (line_length)
//
// A byte is taken every cycle while the job queue has room; the serializer emits one
// character per cycle while rsp_stall is low, and a byte yields 1 to 4 characters.
// A byte's job is written into the queue, then loaded into the output register that
// drives rsp_valid; rsp_stall can hold back that load.
// Reset clears group phase, carry bits, line count and the queue; line length goes to 72.
// req_stall rises only when the queue is full; rsp_stall holds the output register and
// backs up the queue.
module base64_line_encoder
   import b64le_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   q_status_type q_status;
   job_type      push_job;
   job_type      head;
   logic         q_push;
   logic         q_pop;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;

   b64le_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .accept         (q_push),
      .req_data       (req_data),
      .job            (push_job)
   );

   b64le_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   b64le_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_msg_end_on_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_end |-> rsp_data.run_end)
      else $error("message end without run end");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_end |=> rsp_valid)
      else $error("gap inside a byte's characters");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

// ===== dv/base64_line_encoder_test.sv =====
`timescale 1ns / 1ps

module base64_line_encoder_test;
   import b64le_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD   = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [8*64-1:0] B64_SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef enum logic [1:0] {
      AWAIT_FIRST  = 2'd0,
      AWAIT_SECOND = 2'd1,
      AWAIT_THIRD  = 2'd2
   } group_pos_type;

   typedef enum logic {
      STEP_BYTE     = 1'b0,
      STEP_LINE_LEN = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [7:0]    value;
      logic          fin;
      logic [2:0]    n_typed;
      logic [31:0]   typed;
   } script_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_en = 1'b0;
   logic [7:0] csr_write_data = '0;

   group_pos_type grp_phase = AWAIT_FIRST;
   logic [3:0]    carry = '0;
   logic [7:0]    line_cnt = '0;
   logic [7:0]    line_len = LINE_LENGTH_RESET;

   rsp_type char_queue [$];
   int      errors = 0;
   int      bytes_sent = 0;
   int      burst_left = 0;
   int      cycle_count = 0;
   bit      steady_send = 1'b0;
   bit      hold_request = 1'b0;

   script_step_type script [28] = '{
      '{STEP_BYTE,     8'h00, 1'b1, 3'd4, "AA=="},
      '{STEP_BYTE,     8'hff, 1'b1, 3'd4, "/w=="},
      '{STEP_BYTE,     8'hff, 1'b0, 3'd1, "/"},
      '{STEP_BYTE,     8'hff, 1'b1, 3'd3, "/8="},
      '{STEP_BYTE,     8'h00, 1'b0, 3'd1, "A"},
      '{STEP_BYTE,     8'h00, 1'b0, 3'd1, "A"},
      '{STEP_BYTE,     8'h00, 1'b1, 3'd2, "AA"},
      '{STEP_LINE_LEN, 8'd4,  1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h4d, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h61, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h6e, 1'b1, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h10, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'hef, 1'b1, 3'd0, 32'h0},
      '{STEP_LINE_LEN, 8'd12, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h14, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'hfb, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h9c, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h03, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'hd9, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h7e, 1'b0, 3'd0, 32'h0},
      '{STEP_LINE_LEN, 8'd4,  1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h5a, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'ha5, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h3c, 1'b0, 3'd0, 32'h0},
      '{STEP_LINE_LEN, 8'd0,  1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'hc3, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h69, 1'b0, 3'd0, 32'h0},
      '{STEP_BYTE,     8'h96, 1'b1, 3'd0, 32'h0}
   };

   base64_line_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      return B64_SYMBOLS[8*(63 - int'(v)) +: 8];
   endfunction

   function automatic int encode_byte(input req_type item, output rsp_type chars [4]);
      int n;
      int i;
      logic [7:0] b;
      b = item.data_byte;
      for (i = 0; i < 4; i++)
         chars[i] = '0;
      case (grp_phase)
         AWAIT_SECOND: begin
            chars[0].out_char = b64_char({carry[1:0], b[7:4]});
            carry = b[3:0];
            grp_phase = AWAIT_THIRD;
            n = 1;
            if (item.final_byte) begin
               chars[1].out_char = b64_char({b[3:0], 2'b00});
               chars[2].out_char = PAD_CHAR;
               n = 3;
            end
         end
         AWAIT_THIRD: begin
            chars[0].out_char = b64_char({carry, b[7:6]});
            chars[1].out_char = b64_char(b[5:0]);
            carry = '0;
            grp_phase = AWAIT_FIRST;
            line_cnt = line_cnt + 8'd4;
            n = 2;
            if (line_len != 0 && line_cnt == line_len) begin
               line_cnt = '0;
               chars[2].out_char = NEWLINE_CHAR;
               n = 3;
            end
         end
         default: begin
            chars[0].out_char = b64_char(b[7:2]);
            carry = {2'b00, b[1:0]};
            grp_phase = AWAIT_SECOND;
            n = 1;
            if (item.final_byte) begin
               chars[1].out_char = b64_char({b[1:0], 4'b0000});
               chars[2].out_char = PAD_CHAR;
               chars[3].out_char = PAD_CHAR;
               n = 4;
            end
         end
      endcase
      chars[n-1].run_end = 1'b1;
      if (item.final_byte) begin
         chars[n-1].message_end = 1'b1;
         grp_phase = AWAIT_FIRST;
         carry = '0;
         line_cnt = '0;
      end
      return n;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin, input int n_typed,
                            input logic [31:0] typed);
      req_type item;
      rsp_type chars [4];
      int n;
      int count;
      int i;
      if (burst_left == 0) begin
         if (!steady_send) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      item.data_byte = b;
      item.final_byte = fin;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      n = encode_byte(item, chars);
      count = (n_typed != 0) ? n_typed : n;
      for (i = 0; i < count; i++) begin
         if (n_typed != 0) begin
            chars[i].out_char = typed[8*(n_typed-1-i) +: 8];
            chars[i].run_end = (i == count - 1);
            chars[i].message_end = fin && (i == count - 1);
         end
         char_queue.push_back(chars[i]);
      end
      bytes_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (char_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_length(input logic [7:0] v);
      settle();
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      line_len = v;
   endtask

   function automatic logic [7:0] pick_line_length();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'(4 * $urandom_range(1, 6));
         3: return 8'd252;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // receiver stall pattern; long hold-off on request
   initial begin
      int stretch;
      int style;
      int k;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         stretch = $urandom_range(1, 24);
         style = $urandom_range(0, 3);
         for (k = 0; k < stretch && !hold_request; k++) begin
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= (k % 3 == 2);
               default: rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (char_queue.size() == 0) begin
            $display("%0t: unexpected transfer: char %h run_end %b message_end %b",
                     $time, rsp_data.out_char, rsp_data.run_end, rsp_data.message_end);
            errors++;
         end else begin
            want = char_queue.pop_front();
            if (want.out_char !== rsp_data.out_char || want.run_end !== rsp_data.run_end ||
                want.message_end !== rsp_data.message_end) begin
               $display("%0t: expected char %h run %b msg %b, got char %h run %b msg %b",
                        $time, want.out_char, want.run_end, want.message_end,
                        rsp_data.out_char, rsp_data.run_end, rsp_data.message_end);
               errors++;
            end
         end
      end
   end

   initial begin
      int r;
      int k;
      int len;
      int msgs;
      int start_count;
      bit open_tail;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < $size(script); r++) begin
         if (script[r].kind == STEP_LINE_LEN)
            set_line_length(script[r].value);
         else
            send_byte(script[r].value, script[r].fin, int'(script[r].n_typed),
                      script[r].typed);
      end

      start_count = bytes_sent;
      while (bytes_sent - start_count < 24) begin
         set_line_length(pick_line_length());
         msgs = $urandom_range(1, 3);
         open_tail = ($urandom_range(0, 3) == 0);
         repeat (msgs) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
               send_byte(8'($urandom_range(0, 255)),
                         (k == len - 1) && !(open_tail && msgs == 1), 0, 32'h0);
            msgs--;
         end
      end

      // wrap the line count with breaks off; fill the block while the receiver holds off
      set_line_length(8'd0);
      steady_send = 1'b1;
      hold_request = 1'b1;
      for (k = 0; k < 198; k++) begin
         if (k == 30)
            steady_send = 1'b0;
         send_byte(8'($urandom_range(0, 255)), 1'b0, 0, 32'h0);
      end

      // lower the length below the running count, then end the message
      set_line_length(8'd4);
      for (k = 0; k < 7; k++)
         send_byte(8'($urandom_range(0, 255)), k == 6, 0, 32'h0);

      settle();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== base64_line_encoder.f =====
rtl/b64le_pkg.sv
rtl/b64le_front.sv
rtl/b64le_queue.sv
rtl/b64le_back.sv
rtl/base64_line_encoder.sv
dv/base64_line_encoder_test.sv
